// ===== rtl/core/layer_stack_order_manager_unit_assert.svh =====
// Assertion macros for the layer stack order manager checker.
// Both expect signals named aclk and aresetn in the scope of use.
`ifndef LAYER_STACK_ORDER_MANAGER_UNIT_ASSERT_SVH
`define LAYER_STACK_ORDER_MANAGER_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define LSOM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define LSOM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lsom_pkg.sv =====
// Shared constants, types and codes of the layer stack order manager.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package lsom_pkg;

    localparam int LAYER_COUNT = 256;
    // A layer id is 8 bits wide, so at most 256 layers exist.
    localparam int POOL_SIZE   = (LAYER_COUNT < 256) ? LAYER_COUNT : 256;
    localparam int POOL_AW     = $clog2(POOL_SIZE);
    localparam int CNT_W       = POOL_AW + 1;

    localparam int ID_W     = 8;
    localparam int REQ_W    = 10;
    localparam int HGT_W    = 9;
    localparam int STATUS_W = 2;
    localparam int EXT_W    = 11;

    typedef logic signed [HGT_W-1:0] hgt_t;
    typedef logic [POOL_AW-1:0]      addr_t;

    localparam hgt_t HGT_HIDDEN = '1;

    localparam logic CMD_ALLOC      = 1'b0;
    localparam logic CMD_SET_HEIGHT = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd2;

    // Controller to datapath: one strobe per controller step, none for the result wait.
    typedef struct packed {
        logic capture;
        logic decode;
        logic plan;
        logic setup;
        logic step_rd;
        logic step_wr;
        logic finish;
    } lsom_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic alloc;
        logic not_alloc;
        logic same_height;
        logic cnt_zero;
        logic last_step;
    } lsom_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/layer_stack_order_manager_unit.sv =====
// Top level of the layer stack order manager: sequencer plus datapath.
// Depends on lsom_pkg, lsom_ctrl, lsom_datapath (and lsom_ram below it).
//
//  channel | handshake         | payload
//  --------+-------------------+------------------------------------------------
//  s_      | s_valid / s_ready | command, layer_id, requested_height
//  m_      | m_valid / m_ready | status, result_layer, new_height, top_height,
//          |                   | refresh_request
//
// One command at a time. Allocate or refused set height: the result follows the decode
// state. Set height passes decode, plan and setup, then goes straight to the result when
// the height is unchanged, else takes a read and a write of the order-table RAM for each
// table entry shifted, then finish. Input ready again in the cycle after the result transfer.
// Reset (aresetn low, synchronous) frees all layers and empties the stack at once;
// input ready in the cycle after release. A stalled result holds until m_ready.
`timescale 1ns / 1ps
`default_nettype none

module layer_stack_order_manager_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_command,
    input  wire logic        [lsom_pkg::ID_W-1:0]     s_layer_id,
    input  wire logic signed [lsom_pkg::REQ_W-1:0]    s_requested_height,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic             [lsom_pkg::STATUS_W-1:0] m_status,
    output logic             [lsom_pkg::ID_W-1:0]     m_result_layer,
    output logic signed      [lsom_pkg::HGT_W-1:0]    m_new_height,
    output logic signed      [lsom_pkg::HGT_W-1:0]    m_top_height,
    output logic                                      m_refresh_request
);

    lsom_pkg::lsom_cmd_t cmd;
    lsom_pkg::lsom_sts_t sts;

    lsom_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lsom_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .in_command          (s_command),
        .in_layer_id         (s_layer_id),
        .in_requested_height (s_requested_height),
        .res_status          (m_status),
        .res_layer           (m_result_layer),
        .res_new_height      (m_new_height),
        .res_top_height      (m_top_height),
        .res_refresh         (m_refresh_request)
    );

endmodule

`default_nettype wire

// ===== rtl/core/lsom_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lsom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lsom_ctrl.sv =====
// Command sequencer of the layer stack order manager.
// Depends on lsom_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module lsom_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire lsom_pkg::lsom_sts_t sts,
    output lsom_pkg::lsom_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PLAN,
        ST_SETUP,
        ST_STEP_RD,
        ST_STEP_WR,
        ST_FINISH,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        m_valid_next = m_valid_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    state_next   = ST_DECODE;
                    s_ready_next = 1'b0;
                end else begin
                    // open the input once reset has been released
                    s_ready_next = 1'b1;
                end
            end
            ST_DECODE: begin
                if (sts.alloc || sts.not_alloc) begin
                    state_next   = ST_RESULT;
                    m_valid_next = 1'b1;
                end else begin
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN: begin
                state_next = ST_SETUP;
            end
            ST_SETUP: begin
                priority if (sts.same_height) begin
                    state_next   = ST_RESULT;
                    m_valid_next = 1'b1;
                end else if (sts.cnt_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_STEP_RD;
                end
            end
            ST_STEP_RD: begin
                state_next = ST_STEP_WR;
            end
            ST_STEP_WR: begin
                state_next = sts.last_step ? ST_FINISH : ST_STEP_RD;
            end
            ST_FINISH: begin
                state_next   = ST_RESULT;
                m_valid_next = 1'b1;
            end
            ST_RESULT: begin
                if (m_ready) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b0;
                    s_ready_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        cmd         = '0;
        cmd.capture = (state_reg == ST_IDLE) && s_valid && s_ready_reg;
        cmd.decode  = (state_reg == ST_DECODE);
        cmd.plan    = (state_reg == ST_PLAN);
        cmd.setup   = (state_reg == ST_SETUP);
        cmd.step_rd = (state_reg == ST_STEP_RD);
        cmd.step_wr = (state_reg == ST_STEP_WR);
        cmd.finish  = (state_reg == ST_FINISH);
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lsom_datapath.sv =====
// Datapath: layer pool bits, free-layer encoder, order and height RAMs,
// clamp and shift bookkeeping, result registers. Depends on lsom_pkg, lsom_ram.
`timescale 1ns / 1ps
`default_nettype none

module lsom_datapath (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire lsom_pkg::lsom_cmd_t                  cmd,
    output lsom_pkg::lsom_sts_t                       sts,
    input  wire logic                                 in_command,
    input  wire logic        [lsom_pkg::ID_W-1:0]     in_layer_id,
    input  wire logic signed [lsom_pkg::REQ_W-1:0]    in_requested_height,
    output logic             [lsom_pkg::STATUS_W-1:0] res_status,
    output logic             [lsom_pkg::ID_W-1:0]     res_layer,
    output lsom_pkg::hgt_t                            res_new_height,
    output lsom_pkg::hgt_t                            res_top_height,
    output logic                                      res_refresh
);

    localparam logic signed [lsom_pkg::EXT_W-1:0] X_NEG1 = '1;
    localparam logic signed [lsom_pkg::EXT_W-1:0] X_ONE  = lsom_pkg::EXT_W'(1);
    localparam logic signed [lsom_pkg::EXT_W-1:0] X_POOL =
        lsom_pkg::EXT_W'(lsom_pkg::POOL_SIZE);
    localparam logic [lsom_pkg::ID_W:0] ID_LIMIT = (lsom_pkg::ID_W + 1)'(lsom_pkg::POOL_SIZE);

    // Captured command
    logic                                   cmd_reg;
    logic        [lsom_pkg::ID_W-1:0]       id_reg;
    logic signed [lsom_pkg::REQ_W-1:0]      req_reg;

    // Stack state
    lsom_pkg::hgt_t                         top_reg;
    logic        [lsom_pkg::POOL_SIZE-1:0]  used_reg;

    // Free-layer encoder output, registered
    logic                                   free_any_reg;
    lsom_pkg::addr_t                        free_idx_reg;
    logic        [lsom_pkg::POOL_SIZE-1:0]  free_vec, free_iso;
    lsom_pkg::addr_t                        free_idx_c;

    // Move bookkeeping
    lsom_pkg::hgt_t                         old_reg, h_reg;
    lsom_pkg::addr_t                        d_reg, d_next;
    logic        [lsom_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                                   down_reg, down_next;
    logic                                   hide_reg, hide_next;
    logic                                   show_reg, show_next;

    // Result registers
    logic        [lsom_pkg::STATUS_W-1:0]   status_reg;
    logic        [lsom_pkg::ID_W-1:0]       layer_reg;
    lsom_pkg::hgt_t                         newh_reg;
    lsom_pkg::hgt_t                         toph_reg;
    logic                                   refresh_reg;

    // RAM ports
    logic                                   oram_we, hram_we;
    lsom_pkg::addr_t                        oram_waddr, hram_waddr, oram_raddr, hram_raddr;
    logic        [lsom_pkg::ID_W-1:0]       oram_wdata, oram_rdata;
    lsom_pkg::hgt_t                         hram_wdata, hram_rdata;

    lsom_pkg::addr_t                        id_addr;
    logic                                   id_ok, layer_used;

    logic signed [lsom_pkg::EXT_W-1:0]      top_x, old_x, req_x, lim_x, clip_x;
    logic signed [lsom_pkg::EXT_W-1:0]      oldr_x, h_x, cnt_x;
    lsom_pkg::hgt_t                         h_calc;

    assign id_addr    = id_reg[lsom_pkg::POOL_AW-1:0];
    assign id_ok      = ({1'b0, id_reg} < ID_LIMIT);
    assign layer_used = used_reg[id_addr];

    // Lowest free layer: isolate the lowest set bit, then encode it
    always_comb begin
        free_vec   = ~used_reg;
        free_iso   = free_vec & (~free_vec + lsom_pkg::POOL_SIZE'(1));
        free_idx_c = '0;
        for (int j = 0; j < lsom_pkg::POOL_AW; j++) begin
            for (int i = 0; i < lsom_pkg::POOL_SIZE; i++) begin
                if (((i >> j) & 1) == 1) begin
                    free_idx_c[j] = free_idx_c[j] | free_iso[i];
                end
            end
        end
    end

    // Clamp the requested height (plan step; old height arrives from the RAM)
    always_comb begin
        top_x  = lsom_pkg::EXT_W'(top_reg);
        old_x  = lsom_pkg::EXT_W'(hram_rdata);
        req_x  = lsom_pkg::EXT_W'(req_reg);
        lim_x  = (old_x[lsom_pkg::EXT_W-1]) ? (top_x + X_ONE) : top_x;
        clip_x = (req_x > lim_x) ? lim_x : req_x;
        if (clip_x < X_NEG1) begin
            clip_x = X_NEG1;
        end
        // Showing a layer into a full table leaves it hidden
        if (old_x[lsom_pkg::EXT_W-1] && !clip_x[lsom_pkg::EXT_W-1]
            && ((top_x + X_ONE) >= X_POOL)) begin
            clip_x = old_x;
        end
        h_calc = clip_x[lsom_pkg::HGT_W-1:0];
    end

    // Shift span and direction (setup step)
    always_comb begin
        oldr_x    = lsom_pkg::EXT_W'(old_reg);
        h_x       = lsom_pkg::EXT_W'(h_reg);
        d_next    = old_reg[lsom_pkg::POOL_AW-1:0];
        down_next = 1'b0;
        hide_next = 1'b0;
        show_next = 1'b0;
        if (oldr_x > h_x) begin
            if (!h_x[lsom_pkg::EXT_W-1]) begin
                cnt_x     = oldr_x - h_x;
                down_next = 1'b1;
            end else begin
                cnt_x     = top_x - oldr_x;
                hide_next = 1'b1;
            end
        end else begin
            if (!oldr_x[lsom_pkg::EXT_W-1]) begin
                cnt_x = h_x - oldr_x;
            end else begin
                cnt_x     = top_x - h_x + X_ONE;
                d_next    = top_x[lsom_pkg::POOL_AW-1:0] + lsom_pkg::POOL_AW'(1);
                down_next = 1'b1;
                show_next = 1'b1;
            end
        end
        cnt_next = cnt_x[lsom_pkg::CNT_W-1:0];
    end

    always_comb begin
        sts             = '0;
        sts.alloc       = (cmd_reg == lsom_pkg::CMD_ALLOC);
        sts.not_alloc   = (cmd_reg == lsom_pkg::CMD_SET_HEIGHT) && (!id_ok || !layer_used);
        sts.same_height = (old_reg == h_reg);
        sts.cnt_zero    = (cnt_next == '0);
        sts.last_step   = (cnt_reg == lsom_pkg::CNT_W'(1));
    end

    // RAM port selection
    always_comb begin
        oram_raddr = down_reg ? (d_reg - lsom_pkg::POOL_AW'(1)) : (d_reg + lsom_pkg::POOL_AW'(1));
        hram_raddr = id_addr;
        oram_we    = 1'b0;
        oram_waddr = d_reg;
        oram_wdata = oram_rdata;
        hram_we    = 1'b0;
        hram_waddr = id_addr;
        hram_wdata = lsom_pkg::HGT_HIDDEN;
        priority if (cmd.decode && sts.alloc && free_any_reg) begin
            hram_we    = 1'b1;
            hram_waddr = free_idx_reg;
        end else if (cmd.step_wr) begin
            oram_we    = 1'b1;
            hram_we    = 1'b1;
            hram_waddr = oram_rdata[lsom_pkg::POOL_AW-1:0];
            hram_wdata = lsom_pkg::HGT_W'(d_reg);
        end else if (cmd.finish) begin
            hram_we = 1'b1;
            if (!hide_reg) begin
                oram_we    = 1'b1;
                oram_waddr = h_reg[lsom_pkg::POOL_AW-1:0];
                oram_wdata = id_reg;
                hram_wdata = h_reg;
            end
        end
    end

    lsom_ram #(
        .WIDTH(lsom_pkg::ID_W),
        .DEPTH(lsom_pkg::POOL_SIZE)
    ) u_order_ram (
        .aclk  (aclk),
        .we    (oram_we),
        .waddr (oram_waddr),
        .wdata (oram_wdata),
        .raddr (oram_raddr),
        .rdata (oram_rdata)
    );

    lsom_ram #(
        .WIDTH(lsom_pkg::HGT_W),
        .DEPTH(lsom_pkg::POOL_SIZE)
    ) u_height_ram (
        .aclk  (aclk),
        .we    (hram_we),
        .waddr (hram_waddr),
        .wdata (hram_wdata),
        .raddr (hram_raddr),
        .rdata (hram_rdata)
    );

    // Control state: pool bits and top of stack
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            top_reg  <= lsom_pkg::HGT_HIDDEN;
        end else begin
            if (cmd.decode && sts.alloc && free_any_reg) begin
                used_reg[free_idx_reg] <= 1'b1;
            end
            if (cmd.finish) begin
                if (hide_reg) begin
                    top_reg <= top_reg - lsom_pkg::HGT_W'(1);
                end else if (show_reg) begin
                    top_reg <= top_reg + lsom_pkg::HGT_W'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        free_any_reg <= |free_vec;
        free_idx_reg <= free_idx_c;

        if (cmd.capture) begin
            cmd_reg <= in_command;
            id_reg  <= in_layer_id;
            req_reg <= in_requested_height;
        end

        if (cmd.plan) begin
            old_reg <= hram_rdata;
            h_reg   <= h_calc;
        end

        if (cmd.setup) begin
            d_reg    <= d_next;
            cnt_reg  <= cnt_next;
            down_reg <= down_next;
            hide_reg <= hide_next;
            show_reg <= show_next;
        end

        if (cmd.step_wr) begin
            d_reg   <= down_reg ? (d_reg - lsom_pkg::POOL_AW'(1))
                                : (d_reg + lsom_pkg::POOL_AW'(1));
            cnt_reg <= cnt_reg - lsom_pkg::CNT_W'(1);
        end

        if (cmd.decode && sts.alloc) begin
            refresh_reg <= 1'b0;
            newh_reg    <= lsom_pkg::HGT_HIDDEN;
            toph_reg    <= top_reg;
            if (free_any_reg) begin
                status_reg <= lsom_pkg::STATUS_OK;
                layer_reg  <= lsom_pkg::ID_W'(free_idx_reg);
            end else begin
                status_reg <= lsom_pkg::STATUS_NO_FREE;
                layer_reg  <= '0;
            end
        end else if (cmd.decode && sts.not_alloc) begin
            status_reg  <= lsom_pkg::STATUS_NOT_ALLOC;
            layer_reg   <= id_reg;
            newh_reg    <= lsom_pkg::HGT_HIDDEN;
            toph_reg    <= top_reg;
            refresh_reg <= 1'b0;
        end else if (cmd.setup && sts.same_height) begin
            status_reg  <= lsom_pkg::STATUS_OK;
            layer_reg   <= id_reg;
            newh_reg    <= old_reg;
            toph_reg    <= top_reg;
            refresh_reg <= 1'b0;
        end else if (cmd.finish) begin
            status_reg  <= lsom_pkg::STATUS_OK;
            layer_reg   <= id_reg;
            refresh_reg <= 1'b1;
            if (hide_reg) begin
                newh_reg <= lsom_pkg::HGT_HIDDEN;
                toph_reg <= top_reg - lsom_pkg::HGT_W'(1);
            end else begin
                newh_reg <= h_reg;
                toph_reg <= show_reg ? (top_reg + lsom_pkg::HGT_W'(1)) : top_reg;
            end
        end
    end

    assign res_status     = status_reg;
    assign res_layer      = layer_reg;
    assign res_new_height = newh_reg;
    assign res_top_height = toph_reg;
    assign res_refresh    = refresh_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lsom_checker.sv =====
// Port-level checks of the layer stack order manager, bound to the top level.
// Depends on lsom_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "layer_stack_order_manager_unit_assert.svh"

module lsom_checker (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_valid,
    input wire logic                                 s_ready,
    input wire logic                                 s_command,
    input wire logic        [lsom_pkg::ID_W-1:0]     s_layer_id,
    input wire logic signed [lsom_pkg::REQ_W-1:0]    s_requested_height,
    input wire logic                                 m_valid,
    input wire logic                                 m_ready,
    input wire logic        [lsom_pkg::STATUS_W-1:0] m_status,
    input wire logic        [lsom_pkg::ID_W-1:0]     m_result_layer,
    input wire logic signed [lsom_pkg::HGT_W-1:0]    m_new_height,
    input wire logic signed [lsom_pkg::HGT_W-1:0]    m_top_height,
    input wire logic                                 m_refresh_request
);

    logic                                                            m_failed;
    logic [lsom_pkg::STATUS_W+lsom_pkg::ID_W+2*lsom_pkg::HGT_W:0]    m_payload;
    logic [lsom_pkg::ID_W+lsom_pkg::REQ_W:0]                         s_payload;

    assign m_failed  = (m_status != lsom_pkg::STATUS_OK);
    assign m_payload = {m_status, m_result_layer, m_new_height, m_top_height,
                        m_refresh_request};
    assign s_payload = {s_command, s_layer_id, s_requested_height};

    // A pending result blocks new commands
    `LSOM_ASSERT_IMP(a_ready_excl, m_valid, !s_ready, "input ready while a result is pending")

    // Only one command in flight
    `LSOM_ASSERT_NXT(a_one_cmd, s_valid && s_ready, !s_ready, "second transfer accepted")

    // A failed command changes nothing on screen
    `LSOM_ASSERT_IMP(a_fail_quiet, m_valid && m_failed, !m_refresh_request, "refresh on failure")

    // A stalled result holds
    `LSOM_ASSERT_NXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_payload), "result changed")

    // A waiting command holds
    `LSOM_ASSERT_NXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_payload), "input changed")

endmodule

bind layer_stack_order_manager_unit lsom_checker u_lsom_checker (.*);

`default_nettype wire
